// ----- sv/fec_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, character codes and helpers for the filename escaper.
package fec_pkg;

    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_TILDE      = 8'h7E;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_HASH       = 8'h23;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // how one piece of output is formed
    localparam logic [1:0] PK_NONE = 2'd0;   // no bytes
    localparam logic [1:0] PK_ONE  = 2'd1;   // the byte itself
    localparam logic [1:0] PK_ESC  = 2'd2;   // '#' and two hex digits

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
    } t_piece;

    typedef struct packed {
        t_piece pre;     // the held dot, if resolved by this word
        t_piece main;    // this word's own byte
        logic   last;
    } t_desc;

    function automatic logic passes_as_is(input logic [7:0] b);
        logic r;
        r = 1'b0;
        if (b >= 8'h30 && b <= 8'h39) r = 1'b1;
        if (b >= 8'h61 && b <= 8'h7A) r = 1'b1;
        if (b >= 8'h41 && b <= 8'h5A) r = 1'b1;
        case (b)
            8'h21, 8'h40, 8'h24, 8'h25, 8'h26, 8'h28, 8'h29,
            8'h2B, 8'h2C, 8'h2D, 8'h3B, 8'h3D: r = 1'b1;
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10) r = 8'h30 + {4'd0, n};
        else           r = 8'h37 + {4'd0, n};
        return r;
    endfunction

    function automatic logic [2:0] piece_len(input t_piece p);
        logic [2:0] r;
        case (p.kind)
            PK_ONE:  r = 3'd1;
            PK_ESC:  r = 3'd3;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] piece_byte(input t_piece p, input logic [1:0] j);
        logic [7:0] r;
        if (p.kind == PK_ONE) begin
            r = p.value;
        end else begin
            case (j)
                2'd0:    r = CH_HASH;
                2'd1:    r = hex_char(p.value[7:4]);
                default: r = hex_char(p.value[3:0]);
            endcase
        end
        return r;
    endfunction

endpackage

// ----- sv/fec_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input words, classifies them and resolves held dots.
module fec_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [7:0]    i_in_byte,
    input  logic          i_in_last,
    input  logic          i_q_full,
    output logic          o_q_wr,
    output fec_pkg::t_desc o_q_desc
);
    import fec_pkg::*;

    logic  r_dot_pending;
    logic  n_dot_pending;
    logic  accept;
    t_desc desc;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        desc          = '0;
        desc.last     = i_in_last;
        n_dot_pending = 1'b0;
        desc.pre.value = CH_DOT;
        if (r_dot_pending) begin
            desc.pre.kind = (i_in_byte == CH_TILDE) ? PK_ESC : PK_ONE;
        end
        desc.main.value = i_in_byte;
        if (passes_as_is(i_in_byte)) begin
            desc.main.kind = PK_ONE;
        end else if (i_in_byte == CH_SPACE) begin
            desc.main.kind  = PK_ONE;
            desc.main.value = CH_UNDERSCORE;
        end else if (i_in_byte == CH_TILDE) begin
            desc.main.kind  = PK_ONE;
            desc.main.value = CH_SLASH;
        end else if (i_in_byte == CH_DOT) begin
            if (i_in_last) desc.main.kind = PK_ESC;
            else           n_dot_pending  = 1'b1;
        end else begin
            desc.main.kind = PK_ESC;
        end
    end

    assign o_q_desc = desc;
    assign o_q_wr   = accept && (desc.pre.kind != PK_NONE || desc.main.kind != PK_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_pending <= 1'b0;
        end else if (accept) begin
            r_dot_pending <= n_dot_pending;
        end
    end

endmodule

// ----- sv/fec_queue.sv -----
`timescale 1ns / 1ps
// Short descriptor queue between the front and back ends.
module fec_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  fec_pkg::t_desc i_wdata,
    output logic           o_full,
    input  logic           i_rd,
    output fec_pkg::t_desc o_rdata,
    output logic           o_empty
);
    import fec_pkg::*;

    t_desc               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_wr;
    logic                do_rd;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            if (do_rd) r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + (QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- sv/fec_back.sv -----
`timescale 1ns / 1ps
// Back end: expands descriptors into output bytes through an output register.
module fec_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  fec_pkg::t_desc i_q_desc,
    output logic           o_q_rd,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_out_byte,
    output logic           o_run_last,
    output logic           o_name_last
);
    import fec_pkg::*;

    t_desc      r_desc;
    logic       r_busy;
    logic [2:0] r_idx;
    logic       r_ov;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_name_last;

    logic [2:0] pre_len;
    logic [2:0] total;
    logic [2:0] main_idx;
    logic       emit;
    logic       done;
    logic       load;
    logic [7:0] n_byte;

    assign pre_len  = piece_len(r_desc.pre);
    assign total    = pre_len + piece_len(r_desc.main);
    assign main_idx = r_idx - pre_len;
    assign emit     = r_busy && (!r_ov || !i_out_stall);
    assign done     = emit && (r_idx == total - 3'd1);
    assign load     = (!r_busy || done) && !i_q_empty;
    assign o_q_rd   = load;

    always_comb begin
        if (r_idx < pre_len) n_byte = piece_byte(r_desc.pre, r_idx[1:0]);
        else                 n_byte = piece_byte(r_desc.main, main_idx[1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (load) r_desc <= i_q_desc;
        if (emit) begin
            r_byte      <= n_byte;
            r_run_last  <= done;
            r_name_last <= done && r_desc.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (done) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + 3'd1;
            end
            if (emit)             r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_byte  = r_byte;
    assign o_run_last  = r_run_last;
    assign o_name_last = r_name_last;

endmodule

// ----- sv/filename_char_escaper_core.sv -----
`timescale 1ns / 1ps
// Top level of the filename character escaper.
// Takes a name one byte per word and emits the escaped name one byte per word.
// Each input word expands to zero to four output bytes; the output side moves one
// byte per cycle while the output is not stalled, so the sustained rate is set by
// the output count: one byte out per plain byte, three per escaped byte. A dot is
// held until the next word (or the last flag) decides it. A four-entry queue sits
// between the classifier and the expander, so input is taken while earlier words
// are still being expanded. With the block idle, an accepted word goes through the
// queue and descriptor register, then its bytes leave one per cycle unless stalled.
module filename_char_escaper_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_name_last
);
    import fec_pkg::*;

    logic  q_wr;
    logic  q_full;
    logic  q_rd;
    logic  q_empty;
    t_desc q_wdata;
    t_desc q_rdata;

    fec_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .i_q_full   (q_full),
        .o_q_wr     (q_wr),
        .o_q_desc   (q_wdata)
    );

    fec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    fec_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_desc    (q_rdata),
        .o_q_rd      (q_rd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_name_last (o_name_last)
    );

endmodule
